// ===== rtl/core/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants of the RGB Laplacian sharpening unit: payload
// structs of both channels, register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

  // Default size limits of the line stores and row counter
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Channel and pixel widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;

  // Configuration port
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam logic [CFG_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  // Register index, taken from the word address
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Input transaction: one raster pixel
  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } in_pixel_t;

  // Output transaction: one sharpened pixel
  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;
  } out_pixel_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_laplacian_sharpen_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_laplacian_sharpen_3x3_unit
// Streaming 3x3 cross Laplacian sharpening of RGB pixels in raster order,
// with edge replication and two row stores. Results trail the input by one
// row; the last result of a frame carries frame_end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | in_data   (red, green, blue)
//   out_    | output    | out_valid/out_stall| out_data  (red, green, blue,
//           |           |                    |            frame_end)
//   cfg_    | input     | APB, pready high   | frame_width, frame_height
//
// One pixel is taken every clock unless in_stall holds it. The result of a
// pixel is formed once the pixel one row further down is taken; it passes
// the row store read stage and then the output register.
// rst_n clears counters and valid flags; the row stores are not cleared.
// A stalled output holds the read stage, which then stalls the input.
// A register write restarts the stream at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_laplacian_sharpen_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = rls_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rls_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rls_pkg::in_pixel_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rls_pkg::out_pixel_t                  out_data,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rls_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [rls_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [rls_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned CW = rls_pkg::CHAN_W;

  // Per-pixel control carried through the read stage
  typedef struct packed {
    logic emit;
    logic top_row;
    logic down_is_centre;
    logic left_is_centre;
    logic right_is_centre;
    logic frame_end;
  } stage_ctl_t;

  logic [AW:0]               frame_w;
  logic [RW:0]               frame_h;
  logic                      restart;

  logic [AW-1:0]             col_r;
  logic [AW-1:0]             col_nxt;
  logic [RW-1:0]             row_r;
  logic [RW-1:0]             row_nxt;
  logic                      pend_valid_r;
  logic                      pend_valid_nxt;
  logic                      pend_top_r;
  logic                      pend_top_nxt;

  logic [AW:0]               col_inc;
  logic [RW:0]               row_inc;
  logic                      last_col;
  logic                      accept;
  logic                      adv;

  logic                      s1_valid_r;
  stage_ctl_t                s1_ctl_r;
  stage_ctl_t                s1_ctl_nxt;
  logic [AW-1:0]             s1_col_r;
  logic [rls_pkg::PIX_W-1:0] s1_pix_r;
  logic [rls_pkg::PIX_W-1:0] prev_r;
  logic [rls_pkg::PIX_W-1:0] in_pix;

  logic [rls_pkg::PIX_W-1:0] newer_centre;
  logic [rls_pkg::PIX_W-1:0] newer_right;
  logic [rls_pkg::PIX_W-1:0] older_centre;
  logic [rls_pkg::PIX_W-1:0] nb_left;
  logic [rls_pkg::PIX_W-1:0] nb_right;
  logic [rls_pkg::PIX_W-1:0] nb_up;
  logic [rls_pkg::PIX_W-1:0] nb_down;
  logic [rls_pkg::PIX_W-1:0] sharp;

  logic                      out_valid_r;
  rls_pkg::out_pixel_t       out_data_r;

  // Register file
  rls_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .frame_w     (frame_w),
    .frame_h     (frame_h),
    .restart     (restart)
  );

  // Handshake: the read stage moves on unless its result meets a full,
  // stalled output register
  assign adv      = s1_valid_r & (~s1_ctl_r.emit | ~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign accept   = in_valid & ~in_stall;
  assign in_pix   = {in_data.in_red, in_data.in_green, in_data.in_blue};

  // Raster position and row bookkeeping
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign last_col = ~(col_inc < frame_w);

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    pend_valid_nxt = pend_valid_r;
    pend_top_nxt   = pend_top_r;
    if (!last_col) begin
      col_nxt = col_inc[AW-1:0];
    end else begin
      col_nxt        = '0;
      pend_valid_nxt = 1'b1;
      pend_top_nxt   = (row_r == '0);
      row_nxt        = (row_inc < frame_h) ? row_inc[RW-1:0] : '0;
    end
  end

  always_comb begin
    s1_ctl_nxt.emit            = pend_valid_r;
    s1_ctl_nxt.top_row         = pend_top_r;
    s1_ctl_nxt.down_is_centre  = (row_r == '0);
    s1_ctl_nxt.left_is_centre  = (col_r == '0);
    s1_ctl_nxt.right_is_centre = last_col;
    s1_ctl_nxt.frame_end       = (row_r == '0) & last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r        <= '0;
      row_r        <= '0;
      pend_valid_r <= 1'b0;
      pend_top_r   <= 1'b0;
    end else if (accept) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_top_r   <= pend_top_nxt;
    end
  end

  // Row stores
  rls_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk           (clk),
    .rd_en         (accept),
    .rd_addr       (col_r),
    .rd_addr_right (col_inc[AW-1:0]),
    .new_wr_data   (in_pix),
    .old_wr_en     (adv),
    .old_wr_addr   (s1_col_r),
    .old_wr_data   (newer_centre),
    .newer_centre  (newer_centre),
    .newer_right   (newer_right),
    .older_centre  (older_centre)
  );

  // Read stage: hold the pixel and its flags while the stores answer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_col_r <= col_r;
      s1_pix_r <= in_pix;
    end
  end

  // Left neighbour is the centre of the previous transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (adv) begin
      prev_r <= newer_centre;
    end
  end

  // Select neighbours, replicating the centre at the frame edges
  assign nb_left  = s1_ctl_r.left_is_centre  ? newer_centre : prev_r;
  assign nb_right = s1_ctl_r.right_is_centre ? newer_centre : newer_right;
  assign nb_up    = s1_ctl_r.top_row         ? newer_centre : older_centre;
  assign nb_down  = s1_ctl_r.down_is_centre  ? newer_centre : s1_pix_r;

  // Colour lanes, one per channel
  for (genvar g = 0; g < 3; g++) begin : g_lane
    rls_lane u_lane (
      .centre   (newer_centre[g*CW +: CW]),
      .left_px  (nb_left[g*CW +: CW]),
      .right_px (nb_right[g*CW +: CW]),
      .up_px    (nb_up[g*CW +: CW]),
      .down_px  (nb_down[g*CW +: CW]),
      .result   (sharp[g*CW +: CW])
    );
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl_r.emit) begin
      out_data_r.out_red   <= sharp[3*CW-1:2*CW];
      out_data_r.out_green <= sharp[2*CW-1:CW];
      out_data_r.out_blue  <= sharp[CW-1:0];
      out_data_r.frame_end <= s1_ctl_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/rls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rls_cfg_regs
// APB-style register file holding frame width and height. Gives the sizes
// clamped to the supported range and a restart pulse on every write.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = rls_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rls_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned WW = $clog2(MAX_WIDTH) + 1,
  localparam int unsigned HW = $clog2(MAX_HEIGHT) + 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rls_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [rls_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [rls_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready,
  output logic      [WW-1:0]                   frame_w,
  output logic      [HW-1:0]                   frame_h,
  output logic                                 restart
);

  logic [rls_pkg::CFG_WIDTH_W-1:0]  frame_width_r;
  logic [rls_pkg::CFG_HEIGHT_W-1:0] frame_height_r;
  rls_pkg::reg_idx_t                reg_idx;
  logic                             wr_en;

  // Decode the access
  assign cfg_pready = 1'b1;
  assign reg_idx    = rls_pkg::reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign restart    = wr_en;

  // Hold the register values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= rls_pkg::RESET_FRAME_WIDTH;
      frame_height_r <= rls_pkg::RESET_FRAME_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        rls_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_pwdata[rls_pkg::CFG_WIDTH_W-1:0];
        end
        rls_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_pwdata[rls_pkg::CFG_HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      rls_pkg::REG_FRAME_WIDTH:  cfg_prdata = rls_pkg::CFG_DATA_W'(frame_width_r);
      rls_pkg::REG_FRAME_HEIGHT: cfg_prdata = rls_pkg::CFG_DATA_W'(frame_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Clamp the sizes: zero acts as one, beyond the limit as the limit
  always_comb begin
    if (frame_width_r == '0) begin
      frame_w = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      frame_w = WW'(MAX_WIDTH);
    end else begin
      frame_w = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      frame_h = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      frame_h = HW'(MAX_HEIGHT);
    end else begin
      frame_h = HW'(frame_height_r);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rls_line_store.sv =====
// ----------------------------------------------------------------------------
// rls_line_store
// Two row memories. The newer row is read at the centre column and the one
// to its right and written with the incoming pixel; the older row is read at
// the centre column and written from the read stage with the displaced pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_line_store #(
  parameter int unsigned DEPTH = rls_pkg::DEF_MAX_WIDTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  input  wire logic [AW-1:0]              rd_addr_right,
  input  wire logic [rls_pkg::PIX_W-1:0]  new_wr_data,
  input  wire logic                       old_wr_en,
  input  wire logic [AW-1:0]              old_wr_addr,
  input  wire logic [rls_pkg::PIX_W-1:0]  old_wr_data,
  output logic      [rls_pkg::PIX_W-1:0]  newer_centre,
  output logic      [rls_pkg::PIX_W-1:0]  newer_right,
  output logic      [rls_pkg::PIX_W-1:0]  older_centre
);

  logic [rls_pkg::PIX_W-1:0] newer_mem [DEPTH];
  logic [rls_pkg::PIX_W-1:0] older_mem [DEPTH];

  // Read the newer row before it is overwritten at the same column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      newer_centre     <= newer_mem[rd_addr];
      newer_right      <= newer_mem[rd_addr_right];
      newer_mem[rd_addr] <= new_wr_data;
    end
  end

  // Read the older row; bypass a write to the same column in this cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (old_wr_en && (old_wr_addr == rd_addr)) begin
        older_centre <= old_wr_data;
      end else begin
        older_centre <= older_mem[rd_addr];
      end
    end
    if (old_wr_en) begin
      older_mem[old_wr_addr] <= old_wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rls_lane.sv =====
// ----------------------------------------------------------------------------
// rls_lane
// One colour lane: five times the centre minus the four cross neighbours,
// clamped to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_lane (
  input  wire logic [rls_pkg::CHAN_W-1:0] centre,
  input  wire logic [rls_pkg::CHAN_W-1:0] left_px,
  input  wire logic [rls_pkg::CHAN_W-1:0] right_px,
  input  wire logic [rls_pkg::CHAN_W-1:0] up_px,
  input  wire logic [rls_pkg::CHAN_W-1:0] down_px,
  output logic      [rls_pkg::CHAN_W-1:0] result
);

  // 5 * 255 needs 11 bits; one more carries the sign of the difference
  localparam int unsigned SW = rls_pkg::CHAN_W + 4;

  logic [SW-1:0] centre5;
  logic [SW-1:0] ring_sum;
  logic [SW-1:0] diff;

  assign centre5  = (SW'(centre) << 2) + SW'(centre);
  assign ring_sum = SW'(left_px) + SW'(right_px) + SW'(up_px) + SW'(down_px);
  assign diff     = centre5 - ring_sum;

  // Clamp: negative to zero, above the channel range to full scale
  always_comb begin
    if (diff[SW-1]) begin
      result = '0;
    end else if (diff[SW-2:rls_pkg::CHAN_W] != '0) begin
      result = '1;
    end else begin
      result = diff[rls_pkg::CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== verif/rls_sharpen_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rls_sharpen_check
// Watches the pixel, result and register ports of the sharpening unit. On
// every accepted pixel it updates its own copy of the row stores and counters
// and, where a result is due, queues the sharpened pixel it predicts. Every
// accepted result is checked field by field against the oldest queued pixel.
// Mismatches and unexpected results are counted and handed to the testbench top.
// ----------------------------------------------------------------------------

module rls_sharpen_check
  import rls_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire in_pixel_t              in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire out_pixel_t             out_data,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  wire logic                   cfg_pready,
  output int                          mismatch_total,
  output int                          due_count
);

  localparam int REPORT_LIMIT = 10;

  // Own copy of the two row stores and the raster position
  in_pixel_t                upper_row [DEF_MAX_WIDTH];
  in_pixel_t                lower_row [DEF_MAX_WIDTH];
  int unsigned              col_pos;
  int unsigned              row_pos;
  in_pixel_t                left_px;
  bit                       row_ready;
  bit                       row_is_top;
  logic [CFG_WIDTH_W-1:0]   width_reg;
  logic [CFG_HEIGHT_W-1:0]  height_reg;

  out_pixel_t               due_pixels [$];
  int                       reported = 0;

  initial begin
    mismatch_total = 0;
    due_count      = 0;
  end

  // Zero and oversize settings behave as the nearest legal size
  function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Five times the centre less the four cross neighbours, saturated to a byte
  function automatic logic [CHAN_W-1:0] laplace_clamp(
    input logic [CHAN_W-1:0] ce, le, ri, up, dn
  );
    int acc;
    acc = 5 * int'(ce) - int'(le) - int'(ri) - int'(up) - int'(dn);
    if (acc < 0) return '0;
    if (acc > 255) return 8'd255;
    return acc[CHAN_W-1:0];
  endfunction

  function automatic void restart_stream();
    col_pos    = 0;
    row_pos    = 0;
    left_px    = '0;
    row_ready  = 1'b0;
    row_is_top = 1'b0;
  endfunction

  // Take one raster pixel; queue the result for the row above if one is due
  task automatic absorb_pixel(input in_pixel_t px);
    int unsigned w, h, c, r;
    in_pixel_t   ce, le, ri, up, dn;
    out_pixel_t  want;
    w = fit_size(32'(width_reg), DEF_MAX_WIDTH);
    h = fit_size(32'(height_reg), DEF_MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    ce = lower_row[c];
    if (row_ready) begin
      le = (c == 0) ? ce : left_px;
      ri = (c + 1 < w) ? lower_row[c + 1] : ce;
      up = row_is_top ? ce : upper_row[c];
      // first row of a frame: the pending row is the bottom of the last frame
      dn = (r == 0) ? ce : px;
      want.out_red   = laplace_clamp(ce.in_red, le.in_red, ri.in_red, up.in_red, dn.in_red);
      want.out_green = laplace_clamp(ce.in_green, le.in_green, ri.in_green, up.in_green,
                                     dn.in_green);
      want.out_blue  = laplace_clamp(ce.in_blue, le.in_blue, ri.in_blue, up.in_blue,
                                     dn.in_blue);
      want.frame_end = (r == 0) && (c == w - 1);
      due_pixels.push_back(want);
    end
    left_px      = ce;
    upper_row[c] = ce;
    lower_row[c] = px;
    if (c + 1 < w) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      row_ready  = 1'b1;
      row_is_top = (r == 0);
      col_pos    = 0;
      row_pos    = (r + 1 < h) ? r + 1 : 0;
    end
  endtask

  // Compare one accepted result with the oldest queued pixel
  task automatic match_result(input out_pixel_t got);
    out_pixel_t want;
    bit         bad;
    if (due_pixels.size() == 0) begin
      mismatch_total++;
      if (reported < REPORT_LIMIT) begin
        $display("[%0t] unexpected result: r=%0d g=%0d b=%0d end=%0b", $realtime,
                 got.out_red, got.out_green, got.out_blue, got.frame_end);
        reported++;
      end
    end else begin
      want = due_pixels.pop_front();
      bad  = (got.out_red !== want.out_red) || (got.out_green !== want.out_green)
          || (got.out_blue !== want.out_blue) || (got.frame_end !== want.frame_end);
      if (bad) begin
        mismatch_total++;
        if (reported < REPORT_LIMIT) begin
          $display("[%0t] mismatch: exp r=%0d g=%0d b=%0d e=%0b, got r=%0d g=%0d b=%0d e=%0b",
                   $realtime, want.out_red, want.out_green, want.out_blue, want.frame_end,
                   got.out_red, got.out_green, got.out_blue, got.frame_end);
          reported++;
        end
      end
    end
  endtask

  // Track register writes, accepted pixels and accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      restart_stream();
      due_pixels.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[2]))
          REG_FRAME_WIDTH: begin
            width_reg = cfg_pwdata[CFG_WIDTH_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_pwdata[CFG_HEIGHT_W-1:0];
          end
          default: begin
          end
        endcase
        restart_stream();
      end
      if (in_valid && !in_stall) absorb_pixel(in_data);
      if (out_valid && !out_stall) match_result(out_data);
    end
    due_count = due_pixels.size();
  end

endmodule

// ===== verif/tb_rgb_laplacian_sharpen_3x3_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_laplacian_sharpen_3x3_unit
// Drives raster pixels and frame size writes into the sharpening unit and
// stalls its result channel at random. Runs part of a row at the reset size,
// a few directed frames for edges, frame wrap and saturation, then random
// frames from a single pixel up to sixteen per row, with zero and oversize
// settings among them. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_rgb_laplacian_sharpen_3x3_unit;
  import rls_pkg::*;

  localparam int  HOLD_CYCLES   = 240;
  localparam int  SETTLE_CYCLES = 8;
  localparam real RUN_LIMIT_NS  = 7_200_000.0;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  // Directed frames: 3 wide by 2 high, then a single column 3 high
  localparam in_pixel_t EDGE_PX [12] = '{
    24'hFFFFFF, 24'h000000, 24'hFF00FF,
    24'h00FF00, 24'hFFFFFF, 24'h000000,
    24'h808080, 24'h7F01FE, 24'hFFFFFF,
    24'h010203, 24'hFEFDFC, 24'h404040
  };
  localparam in_pixel_t COLUMN_PX [6] = '{
    24'h00FF80, 24'hFF0080, 24'h80FF00,
    24'h123456, 24'hFFFFFF, 24'h000000
  };

  // Random frame sizes: width, height and pixel count per setting
  localparam int PLAN_N = 11;
  localparam int unsigned PLAN_W [PLAN_N] = '{5, 1, 0, 2, 7, 4, 1, 3, 16, 6, 13};
  localparam int unsigned PLAN_H [PLAN_N] = '{4, 1, 0, 3, 5, 1, 6, 8191, 2, 4096, 3};
  localparam int unsigned PLAN_PX [PLAN_N] =
    '{40, 12, 10, 30, 50, 24, 20, 30, 40, 30, 40};
  localparam int HOLD_PLAN = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_pixel_t             in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_pixel_t            out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int        mismatch_total;
  int        due_count;
  pace_t     pace = PACE_FREE;
  int        sender_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        pushed_total = 0;
  bit        long_hold_go = 1'b0;
  bit        hold_taken = 1'b0;
  int        hold_left = 0;
  in_pixel_t smooth_base = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rgb_laplacian_sharpen_3x3_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rls_sharpen_check check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_total (mismatch_total),
    .due_count      (due_count)
  );

  // Stall the result channel; take the single long hold once it is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (long_hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Half the pixels sit near a drifting base so results land off the rails
  function automatic in_pixel_t make_pixel();
    in_pixel_t px;
    if ($urandom_range(7) == 0) smooth_base = in_pixel_t'(PIX_W'($urandom));
    if ($urandom_range(1) == 0) begin
      px = in_pixel_t'(PIX_W'($urandom));
    end else begin
      px.in_red   = smooth_base.in_red + 8'($urandom_range(15));
      px.in_green = smooth_base.in_green + 8'($urandom_range(15));
      px.in_blue  = smooth_base.in_blue + 8'($urandom_range(15));
    end
    return px;
  endfunction

  // Offer one pixel transaction; enter and leave at a rising edge
  task automatic push_pixel(input in_pixel_t px);
    if (pushed_total % 37 == 0) begin
      pace = pace.next();
      case (pace)
        PACE_FREE: begin
          sender_idle_pct = 0;
          rx_stall_pct   <= 0;
        end
        PACE_SENDER: begin
          sender_idle_pct = 66;
          rx_stall_pct   <= 0;
        end
        PACE_RECEIVER: begin
          sender_idle_pct = 0;
          rx_stall_pct   <= 66;
        end
        default: begin
          sender_idle_pct = 11;
          rx_stall_pct   <= 11;
        end
      endcase
    end
    pushed_total++;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // One register write: setup then access, junk in the unused upper bits
  task automatic write_size_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] junk;
    logic [31:0] word;
    junk = $urandom;
    word = (idx == REG_FRAME_WIDTH) ? {junk[31:12], value[11:0]}
                                    : {junk[31:13], value[12:0]};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    write_size_reg(REG_FRAME_WIDTH, w);
    write_size_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Drop valid, let every queued result drain, then allow the pipe to empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: part of the first 640 pixel row, so no result is due yet
    for (int i = 0; i < 20; i++) push_pixel(make_pixel());
    drain_results();

    // directed: corners, saturation both ways, frame wrap and frame end
    set_frame_size(3, 2);
    foreach (EDGE_PX[i]) push_pixel(EDGE_PX[i]);
    drain_results();
    set_frame_size(1, 3);
    foreach (COLUMN_PX[i]) push_pixel(COLUMN_PX[i]);
    drain_results();

    // random frames over the planned sizes
    for (int p = 0; p < PLAN_N; p++) begin
      set_frame_size(PLAN_W[p], PLAN_H[p]);
      for (int i = 0; i < PLAN_PX[p]; i++) begin
        if (p == HOLD_PLAN && i == 20) long_hold_go <= 1'b1;
        push_pixel(make_pixel());
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && due_count == 0) begin
      $display("rgb_laplacian_sharpen_3x3_unit test passed");
    end else begin
      $display("rgb_laplacian_sharpen_3x3_unit test failed");
    end
    $finish;
  end

  // Run time limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("rgb_laplacian_sharpen_3x3_unit test failed");
    $finish;
  end

endmodule
